[design/lzd_pkg.sv]
// lzd_pkg: types, constants and register map of the lzss byte decompressor
// no dependencies; imported by the output interface and the top level
package lzd_pkg;

    localparam int HIST_AW    = 13;              // history address bits
    localparam int HIST_DEPTH = 1 << HIST_AW;    // history entries
    localparam int COUNT_W    = 24;              // output byte counter width
    localparam int DIST_W     = 13;              // copy distance, up to 4110
    localparam int RUN_W      = 9;               // literal run counter, up to 256
    localparam int LEN_W      = 4;               // copy length nibble
    localparam int ADDR_W     = 3;               // apb byte address width
    localparam int DATA_W     = 32;              // apb data width

    localparam logic [7:0]        TOK_LITERAL  = 8'h80;
    localparam logic [7:0]        TOK_RUN      = 8'h00;
    localparam logic [DIST_W-1:0] DIST_BIAS    = DIST_W'(15);
    localparam logic [COUNT_W-1:0] MAX_OUT_RST = {COUNT_W{1'b1}};

    localparam logic [ADDR_W-1:0] ADDR_MAX_OUTPUT = ADDR_W'(0);

    typedef enum logic [2:0] {
        PH_TOKEN,
        PH_LIT1,
        PH_COUNT,
        PH_RUN,
        PH_CODEH,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        CP_IDLE,
        CP_PRIME,
        CP_RUN
    } t_copy;

endpackage

[design/lzd_in_if.sv]
// lzd_in_if: compressed byte stream channel, valid/ready handshake
// depends on nothing; used by the top level
interface lzd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, in_byte, in_last, input ready);
    modport sink   (input valid, in_byte, in_last, output ready);
endinterface

[design/lzd_out_if.sv]
// lzd_out_if: decompressed byte stream channel, valid/ready handshake
// depends on lzd_pkg for the counter width
interface lzd_out_if;
    import lzd_pkg::*;

    logic               valid;
    logic               ready;
    logic [7:0]         out_byte;
    logic               burst_last;
    logic               block_done;
    logic [COUNT_W-1:0] out_count;
    logic               bad_reference;

    modport source (output valid, out_byte, burst_last, block_done, out_count,
                    bad_reference, input ready);
    modport sink   (input valid, out_byte, burst_last, block_done, out_count,
                    bad_reference, output ready);
endinterface

[design/lzss_byte_decompressor.sv]
// lzss_byte_decompressor: token parser, 8 KiB history memory and copy engine
// timing: a literal enters the output register at its transfer; a copy passes from the
// code high byte through CP_PRIME and the registered history read to CP_RUN, one byte a
// cycle into the output register while it is free; input is held until the copy ends
// throughput: one input byte a cycle while no copy runs and the output is free; the
// single history read port and the output register set one byte a cycle
// reset: synchronous active low, clears parser, counters, copy engine and output valid;
// history memory is not cleared (unwritten entries lie before block start and read as zero)
module lzss_byte_decompressor (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    lzd_in_if.sink                      i_in,
    lzd_out_if.source                   o_out,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [lzd_pkg::ADDR_W-1:0]  i_paddr,
    input  logic [lzd_pkg::DATA_W-1:0]  i_pwdata,
    output logic [lzd_pkg::DATA_W-1:0]  o_prdata,
    output logic                        o_pready
);
    import lzd_pkg::*;

    // history memory, one write and one registered read per cycle
    logic [7:0] r_hist [HIST_DEPTH];
    logic [7:0] r_rd_data;

    // parser and counters
    t_phase              r_phase, n_phase;
    logic [7:0]          r_code_low, n_code_low;
    logic [RUN_W-1:0]    r_run, n_run;
    logic [HIST_AW-1:0]  r_wp, n_wp;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic [COUNT_W-1:0]  r_max, n_max;

    // copy engine
    t_copy               r_cp_state, n_cp_state;
    logic [LEN_W-1:0]    r_cp_rem, n_cp_rem;
    logic [DIST_W-1:0]   r_dist, n_dist;
    logic                r_cp_last, n_cp_last;

    // output register
    logic                r_ov;
    logic [7:0]          r_o_byte;
    logic                r_o_burst_last;
    logic                r_o_block_done;
    logic [COUNT_W-1:0]  r_o_count;
    logic                r_o_bad;

    // datapath helpers
    t_phase              eff_phase;
    logic                out_free;
    logic                in_fire;
    logic                lit_emit;
    logic                cp_emit;
    logic                emit;
    logic                cp_bad;
    logic [7:0]          emit_byte;
    logic [COUNT_W-1:0]  cnt_inc;
    logic                hit;
    logic                emit_burst_last;
    logic                emit_block_done;
    logic [HIST_AW-1:0]  rd_addr;
    logic                cfg_wr;
    logic [LEN_W-1:0]    code_len;

    // the output register frees up when empty or when its transfer completes
    assign out_free = !r_ov || o_out.ready;
    assign in_fire  = i_in.valid && i_in.ready;
    assign cfg_wr   = i_psel && i_penable && i_pwrite && (i_paddr == ADDR_MAX_OUTPUT);
    assign code_len = r_code_low[LEN_W-1:0];

    // a parser that reached the limit drops to discard before looking at the byte
    always_comb begin
        eff_phase = r_phase;
        if (r_phase != PH_DONE && !(r_count < r_max)) begin
            eff_phase = PH_DONE;
        end
    end

    // per-byte result: literal from the input, copy byte from the history read
    always_comb begin
        lit_emit  = in_fire && (eff_phase == PH_LIT1 || eff_phase == PH_RUN);
        cp_emit   = (r_cp_state == CP_RUN) && out_free;
        emit      = lit_emit || cp_emit;
        // source before block start reads as zero and is flagged
        cp_bad    = r_count < COUNT_W'(r_dist);
        cnt_inc   = r_count + COUNT_W'(1);
        hit       = !(cnt_inc < r_max);
        if (lit_emit) begin
            emit_byte       = i_in.in_byte;
            emit_burst_last = 1'b1;
            emit_block_done = i_in.in_last || hit;
        end else begin
            emit_byte       = cp_bad ? 8'h00 : r_rd_data;
            emit_burst_last = (r_cp_rem == LEN_W'(1)) || hit;
            emit_block_done = emit_burst_last && (r_cp_last || hit);
        end
        // read one byte ahead so the data lines up with the write pointer
        // of the next cycle; distance is at least 15, so no read meets a
        // write still in flight
        rd_addr = (cp_emit ? r_wp + HIST_AW'(1) : r_wp) - HIST_AW'(r_dist);
    end

    // next state of parser, counters and copy engine
    always_comb begin
        n_phase    = r_phase;
        n_code_low = r_code_low;
        n_run      = r_run;
        n_wp       = r_wp;
        n_count    = r_count;
        n_max      = r_max;
        n_cp_state = r_cp_state;
        n_cp_rem   = r_cp_rem;
        n_dist     = r_dist;
        n_cp_last  = r_cp_last;

        if (cfg_wr) begin
            n_max = i_pwdata[COUNT_W-1:0];
        end

        if (emit) begin
            n_wp    = r_wp + HIST_AW'(1);
            n_count = cnt_inc;
        end

        if (in_fire) begin
            case (eff_phase)
                PH_TOKEN: begin
                    if (i_in.in_byte == TOK_LITERAL) begin
                        n_phase = PH_LIT1;
                    end else if (i_in.in_byte == TOK_RUN) begin
                        n_phase = PH_COUNT;
                    end else begin
                        n_code_low = i_in.in_byte;
                        n_phase    = PH_CODEH;
                    end
                end
                PH_LIT1: begin
                    n_phase = hit ? PH_DONE : PH_TOKEN;
                end
                PH_COUNT: begin
                    n_run   = {1'b0, i_in.in_byte} + RUN_W'(1);
                    n_phase = PH_RUN;
                end
                PH_RUN: begin
                    if (r_run != '0) begin
                        n_run = r_run - RUN_W'(1);
                    end
                    n_phase = (n_run == '0) ? PH_TOKEN : PH_RUN;
                    if (hit) begin
                        n_phase = PH_DONE;
                    end
                end
                PH_CODEH: begin
                    n_phase = PH_TOKEN;
                    if (code_len != '0) begin
                        n_cp_state = CP_PRIME;
                        n_cp_rem   = code_len;
                        n_dist     = {1'b0, i_in.in_byte, r_code_low[7:LEN_W]} + DIST_BIAS;
                        n_cp_last  = i_in.in_last;
                    end
                end
                default: begin
                    n_phase = PH_DONE;
                end
            endcase

            if (i_in.in_last) begin
                n_code_low = '0;
                n_run      = '0;
                n_phase    = PH_TOKEN;
                // a running copy still needs the count, clear it at its end
                if (!(eff_phase == PH_CODEH && code_len != '0)) begin
                    n_count = '0;
                end
            end
        end

        case (r_cp_state)
            CP_IDLE: begin
            end
            CP_PRIME: begin
                n_cp_state = CP_RUN;
            end
            CP_RUN: begin
                if (cp_emit) begin
                    n_cp_rem = r_cp_rem - LEN_W'(1);
                    if (emit_burst_last) begin
                        n_cp_state = CP_IDLE;
                        if (hit) begin
                            n_phase = PH_DONE;
                        end
                        if (r_cp_last) begin
                            n_phase = PH_TOKEN;
                            n_count = '0;
                        end
                    end
                end
            end
            default: begin
                n_cp_state = CP_IDLE;
            end
        endcase
    end

    // port outputs
    always_comb begin
        i_in.ready          = (r_cp_state == CP_IDLE) && out_free;
        o_out.valid         = r_ov;
        o_out.out_byte      = r_o_byte;
        o_out.burst_last    = r_o_burst_last;
        o_out.block_done    = r_o_block_done;
        o_out.out_count     = r_o_count;
        o_out.bad_reference = r_o_bad;
        o_prdata            = DATA_W'(r_max);
        o_pready            = 1'b1;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_TOKEN;
            r_code_low <= '0;
            r_run      <= '0;
            r_wp       <= '0;
            r_count    <= '0;
            r_max      <= MAX_OUT_RST;
            r_cp_state <= CP_IDLE;
            r_cp_rem   <= '0;
            r_dist     <= '0;
            r_cp_last  <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_code_low <= n_code_low;
            r_run      <= n_run;
            r_wp       <= n_wp;
            r_count    <= n_count;
            r_max      <= n_max;
            r_cp_state <= n_cp_state;
            r_cp_rem   <= n_cp_rem;
            r_dist     <= n_dist;
            r_cp_last  <= n_cp_last;
            if (emit) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // output payload, loaded with each result
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_o_byte       <= emit_byte;
            r_o_burst_last <= emit_burst_last;
            r_o_block_done <= emit_block_done;
            r_o_count      <= cnt_inc;
            r_o_bad        <= cp_emit && cp_bad;
        end
    end

    // history write of every result byte
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_hist[r_wp] <= emit_byte;
        end
    end

    // history read, registered
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_hist[rd_addr];
    end

endmodule
